// ===== rtl/core/bfg_pkg.sv =====
// bfg_pkg: shared widths, register decode, curve table and limits for the fuel gauge
// used by bfg_div and battery_fuel_gauge_core; no dependencies
`default_nettype none

package bfg_pkg;

  // field widths
  localparam int MV_W    = 13;
  localparam int PCT_W   = 7;
  localparam int HOURS_W = 18;

  // shared divider: denominator covers diff * 60 with diff up to 13 bits
  localparam int DEN_W          = 19;
  localparam int DIV_NUM_W_DEF  = 24;
  localparam int HISTORY_DEPTH_DEF = 8;

  // register reset values and charge detection margin
  localparam logic [MV_W-1:0] FULL_RESET    = 13'd4150;
  localparam logic [MV_W-1:0] EMPTY_RESET   = 13'd3300;
  localparam logic [MV_W:0]   CHARGE_MARGIN = 14'd40;

  // register index, taken from paddr[2]
  localparam logic CFG_FULL  = 1'b0;
  localparam logic CFG_EMPTY = 1'b1;

  // reciprocal of ten for the filter, exact for sums below 2^18
  localparam logic [15:0] FILTER_RECIP = 16'd52429;
  localparam int          FILTER_SHIFT = 19;

  // minutes per hour for the estimate denominator
  localparam logic [5:0]  MINUTE_DEN = 6'd60;

  // discharge curve, highest voltage first
  localparam int CURVE_POINTS = 13;
  localparam int SEG_W        = 4;
  localparam int OFF_W        = 7;
  localparam int RISE_W       = 4;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4180, 13'd4100, 13'd4000, 13'd3900, 13'd3820, 13'd3750, 13'd3700,
    13'd3660, 13'd3620, 13'd3560, 13'd3480, 13'd3400, 13'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd88, 7'd78, 7'd68, 7'd57, 7'd46,
    7'd36, 7'd26, 7'd16, 7'd8, 7'd3, 7'd0
  };
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // saturation limits of the signed Q10.8 estimate
  localparam int HOURS_POS_LIM = 131071;
  localparam int HOURS_NEG_LIM = 131072;
  localparam logic [HOURS_W-1:0] HOURS_MAX = 18'h1FFFF;
  localparam logic [HOURS_W-1:0] HOURS_MIN = 18'h20000;

endpackage

`default_nettype wire

// ===== rtl/core/bfg_div.sv =====
// bfg_div: restoring unsigned divider, one quotient bit per cycle
// depends on bfg_pkg for the denominator width
`default_nettype none

module bfg_div import bfg_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;
  logic             ge;

  // shift in the next numerator bit and try a subtract
  assign rem_sh = {rem, quot[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den_r};
  assign ge     = ~trial[DEN_W+1];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], ge};
      rem  <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/battery_fuel_gauge_core.sv =====
// battery_fuel_gauge_core: voltage filter, discharge curve lookup and runtime estimate
// depends on bfg_pkg and bfg_div (shared divider)
//
// Usage: one voltage sample per transaction on the s_axis channel, one result
// per sample on the m_axis channel. The user must write the thresholds over the
// APB port only while idle; the block does not enforce it. pready is tied high
// and reads return the registers. A sample goes through a small sequencer that
// runs both variable divisions, the curve interpolation and the runtime estimate,
// on one shared bit-serial divider (NUM_W = 21 + clog2(HISTORY_DEPTH) bits wide);
// the filter divides by ten with a reciprocal multiply in a single step.
// When the voltage sits at a curve end and no estimate is due, both divisions
// are skipped. The next sample can be accepted in the cycle after the result
// is loaded.
// One sample is in work at a time: s_axis_tready is high only while idle.
// The result waits in an output register; the next sample is accepted while
// it waits, and a stalled receiver only holds the sequencer at its last step.
// Reset clears the thresholds to their defaults, the filter to the no-sample
// state, the history ring and the estimate. No clearing pass is needed.
`default_nettype none

module battery_fuel_gauge_core import bfg_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // sample channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // battery_mv[12:0], history_due[13], zero[15:14]
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // filtered_mv[12:0], charge_percent[19:13],
                                          // charging[20], hours_left_q8[38:21],
                                          // hours_left_valid[39]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int NUM_W = MV_W + IDX_W + 8;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FILT   = 9'b000000010,
    S_PCT    = 9'b000000100,
    S_PSTART = 9'b000001000,
    S_PDIV   = 9'b000010000,
    S_HIST   = 9'b000100000,
    S_HEST   = 9'b001000000,
    S_HDIV   = 9'b010000000,
    S_DONE   = 9'b100000000
  } seq_state_t;

  seq_state_t state;

  logic [MV_W-1:0]    full_mv;
  logic [MV_W-1:0]    empty_mv;
  logic [MV_W-1:0]    mv_in;
  logic               due_in;
  logic [MV_W-1:0]    filt;
  logic [MV_W-1:0]    seed;
  logic [HISTORY_DEPTH-1:0] hist_valid;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   oidx;
  logic [MV_W-1:0]    hist_mem [HISTORY_DEPTH];
  logic [MV_W-1:0]    hist_rdata;
  logic [HOURS_W-1:0] rem_hours;
  logic               rem_valid;
  logic [PCT_W-1:0]   pct_r;
  logic               charging_r;
  logic [SEG_W-1:0]   seg_r;
  logic [MV_W-1:0]    diff_r;
  logic               neg_r;

  logic               in_accept;
  logic               cfg_write;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  logic [16:0]        filt_sum;
  logic [31:0]        filt_prod;
  logic [MV_W-1:0]    filt_avg;
  logic [SEG_W-1:0]   seg;
  logic               at_top;
  logic               at_bottom;
  logic               charging;
  logic [SEG_W-1:0]   seg_prev;
  logic [MV_W-1:0]    seg_off;
  logic [MV_W-1:0]    seg_span;
  logic [PCT_W-1:0]   seg_rise;
  logic [OFF_W+RISE_W-1:0] pct_prod;
  logic [MV_W-1:0]    oldest;
  logic               drop;
  logic [MV_W-1:0]    diff;
  logic [15:0]        diff5;
  logic [MV_W:0]      delta;
  logic [MV_W-1:0]    delta_mag;
  logic [MV_W+IDX_W-1:0] est_prod;
  logic [HOURS_W-1:0] hours_sat;
  logic [HOURS_W-1:0] hours_out;

  assign pready        = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_write     = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_mv  <= FULL_RESET;
      empty_mv <= EMPTY_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        CFG_FULL:  full_mv  <= pwdata[MV_W-1:0];
        CFG_EMPTY: empty_mv <= pwdata[MV_W-1:0];
        default:   full_mv  <= full_mv;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_FULL: prdata = {{(32-MV_W){1'b0}}, full_mv};
      default:  prdata = {{(32-MV_W){1'b0}}, empty_mv};
    endcase
  end

  // filter sum 9 * old + new, divided by ten through the reciprocal
  assign filt_sum  = {1'b0, filt, 3'b000} + {4'b0, filt} + {4'b0, mv_in};
  assign filt_prod = {15'b0, filt_sum} * {16'b0, FILTER_RECIP};
  assign filt_avg  = filt_prod[FILTER_SHIFT +: MV_W];

  // curve segment search, highest-voltage matching breakpoint wins
  always_comb begin
    seg = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (filt >= CURVE_MV[i]) seg = SEG_W'(i);
    end
  end

  assign at_top    = (filt >= CURVE_MV[0]);
  assign at_bottom = (filt <= CURVE_MV[CURVE_POINTS-1]);
  assign charging  = ({1'b0, filt} > ({1'b0, full_mv} + CHARGE_MARGIN));

  // interpolation terms for the registered segment
  assign seg_prev = seg_r - 1'b1;
  assign seg_off  = filt - CURVE_MV[seg_r];
  assign seg_span = CURVE_MV[seg_prev] - CURVE_MV[seg_r];
  assign seg_rise = CURVE_PCT[seg_prev] - CURVE_PCT[seg_r];
  assign pct_prod = {{RISE_W{1'b0}}, seg_off[OFF_W-1:0]} *
                    {{OFF_W{1'b0}}, seg_rise[RISE_W-1:0]};

  // history ring: oldest entry and drop across the ring
  assign oidx   = (pos == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos + 1'b1;
  assign oldest = hist_valid[oidx] ? hist_rdata : seed;
  assign drop   = (oldest != '0) && (oldest > filt);
  assign diff   = oldest - filt;
  assign diff5  = {3'b0, diff} + {1'b0, diff, 2'b00};

  // estimate numerator magnitude and sign
  assign delta     = {1'b0, filt} - {1'b0, empty_mv};
  assign delta_mag = delta[MV_W] ? MV_W'(-delta) : delta[MV_W-1:0];
  assign est_prod  = {{IDX_W{1'b0}}, delta_mag} * (MV_W+IDX_W)'(HISTORY_DEPTH - 1);

  // saturate the quotient and apply the sign
  always_comb begin
    if (neg_r) begin
      hours_sat = (div_quot > NUM_W'(HOURS_NEG_LIM)) ? HOURS_MIN : -div_quot[HOURS_W-1:0];
    end else begin
      hours_sat = (div_quot > NUM_W'(HOURS_POS_LIM)) ? HOURS_MAX : div_quot[HOURS_W-1:0];
    end
  end

  // divider request per sequencer step
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_PSTART: begin
        div_start = 1'b1;
        div_num   = NUM_W'(pct_prod);
        div_den   = DEN_W'(seg_span);
      end
      S_HEST: begin
        div_start = 1'b1;
        div_num   = {est_prod, 8'h00};
        div_den   = {6'b0, diff_r} * DEN_W'(MINUTE_DEN);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bfg_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // history memory, read at accept and written at the minute mark
  always_ff @(posedge clk) begin
    if (in_accept) hist_rdata <= hist_mem[oidx];
    if (state == S_HIST && due_in) hist_mem[pos] <= filt;
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mv_in  <= s_axis_tdata[MV_W-1:0];
      due_in <= s_axis_tdata[MV_W];
    end
  end

  // sequencer and gauge state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      filt       <= '0;
      seed       <= '0;
      hist_valid <= '0;
      pos        <= '0;
      rem_hours  <= '0;
      rem_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) state <= S_FILT;
        end
        S_FILT: begin
          if (filt == '0) begin
            filt       <= mv_in;
            seed       <= mv_in;
            hist_valid <= '0;
          end else begin
            filt <= filt_avg;
          end
          state <= S_PCT;
        end
        S_PCT: begin
          charging_r <= charging;
          seg_r      <= seg;
          if (at_top) begin
            pct_r <= PCT_FULL;
            state <= S_HIST;
          end else if (at_bottom) begin
            pct_r <= PCT_EMPTY;
            state <= S_HIST;
          end else begin
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            pct_r <= CURVE_PCT[seg_r] + div_quot[PCT_W-1:0];
            state <= S_HIST;
          end
        end
        S_HIST: begin
          diff_r <= diff;
          neg_r  <= delta[MV_W];
          state  <= S_DONE;
          if (due_in) begin
            hist_valid[pos] <= 1'b1;
            pos             <= oidx;
            if (drop) begin
              if (diff5 > 16'(HISTORY_DEPTH - 1)) state <= S_HEST;
            end else if (charging_r) begin
              rem_valid <= 1'b0;
            end
          end
        end
        S_HEST: begin
          state <= S_HDIV;
        end
        S_HDIV: begin
          if (div_done) begin
            rem_hours <= hours_sat;
            rem_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign hours_out = rem_valid ? rem_hours : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {rem_valid, hours_out, charging_r, pct_r, filt};
    end
  end

  // a new result only comes out of the final sequencer step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the final step");

  // the divider only finishes while the sequencer waits on it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_PDIV || state == S_HDIV))
    else $error("divider finished with no step waiting");

  // percentage stays on the curve range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:13] <= PCT_FULL))
    else $error("charge percent above full");

  // an invalid estimate is reported as zero
  a_hours_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[39]) |-> (m_axis_tdata[38:21] == '0))
    else $error("invalid estimate with nonzero hours");

endmodule

`default_nettype wire
